FILE: sv/latency_histogram_percentiles_assert.svh
// Assertion macros for the latency histogram block.
// Both sample on clk and are switched off while rst is high.
`ifndef LATENCY_HISTOGRAM_PERCENTILES_ASSERT_SVH
`define LATENCY_HISTOGRAM_PERCENTILES_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define LHP_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define LHP_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lhp_pkg;

  // Operation codes of the command word
  localparam logic [1:0] FUNC_RECORD = 2'd0;
  localparam logic [1:0] FUNC_REPORT = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  // Saturation limits of the wide result fields
  localparam logic [43:0] TOTAL_MAX = '1;
  localparam logic [55:0] WSUM_MAX  = '1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] latency;
    logic [11:0] bin_index;
  } cmd_word_t;

  typedef struct packed {
    logic        empty_res;
    logic [43:0] total_count;
    logic [55:0] weighted_sum;
    logic [11:0] max_bin;
    logic [11:0] p95_bin;
    logic [11:0] p99_bin;
    logic [11:0] p999_bin;
    logic [31:0] bin_count;
    logic        above_floor;
  } rsp_word_t;

endpackage

`default_nettype wire

FILE: sv/latency_histogram_percentiles.sv
`timescale 1ns / 1ps
`default_nettype none
`include "latency_histogram_percentiles_assert.svh"
// Steps: record reads the bin memory, then writes back; read goes through the memory read
// and the result register; report scans the bin memory one bin per cycle, twice unless the total is zero.
// Throughput: one word in work at a time, set by the state machine, which stalls commands
// outside its idle state; a finished result waits in its own register while the next word runs.
// Reset: synchronous; clears control state, then a clearing pass writes zero to all BINS
// bins, one per cycle, during which no command word is taken (config writes still are).
module latency_histogram_percentiles #(
  parameter int BINS        = 4096,
  parameter int COUNT_WIDTH = 32
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cmd_valid,
  output logic                  cmd_stall,
  input  lhp_pkg::cmd_word_t    cmd,
  output logic                  rsp_valid,
  input  wire                   rsp_stall,
  output lhp_pkg::rsp_word_t    rsp,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [4:0]            cfg_data
);
  import lhp_pkg::*;

  localparam int BIN_W = $clog2(BINS);
  localparam int SW    = COUNT_WIDTH + BIN_W;  // scanned sum
  localparam int XW    = SW + 11;              // sums scaled by 100 or 1000
  localparam logic [BIN_W-1:0]       LAST_BIN  = BIN_W'(BINS - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_REC  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_P1   = 4'd4;
  localparam logic [3:0] S_P1E  = 4'd5;
  localparam logic [3:0] S_TH   = 4'd6;
  localparam logic [3:0] S_P2   = 4'd7;
  localparam logic [3:0] S_P2E  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]             state;
  logic [3:0]             state_next;
  logic [4:0]             bucket_shift;
  logic [43:0]            total_samples;
  logic [BIN_W-1:0]       clr_idx;
  logic [BIN_W-1:0]       scan_idx;
  logic [BIN_W-1:0]       cur_addr;
  logic                   cur_ok;

  // bin memory
  logic [COUNT_WIDTH-1:0] mem [BINS];
  logic                   mem_we;
  logic [BIN_W-1:0]       mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [BIN_W-1:0]       mem_raddr;
  logic [COUNT_WIDTH-1:0] rdata;

  // scan pipeline
  logic                   rv;
  logic [BIN_W-1:0]       ridx;
  logic                   pv;
  logic [BIN_W-1:0]       pidx;
  logic [COUNT_WIDTH-1:0] pcnt;
  logic [SW-1:0]          pprod;
  logic [XW-1:0]          pm100;
  logic [XW-1:0]          pm1000;

  // report accumulators
  logic [SW-1:0]          sum;
  logic [55:0]            wsum;
  logic [BIN_W-1:0]       maxb;
  logic [SW-1:0]          cum;
  logic [XW-1:0]          c100;
  logic [XW-1:0]          c1000;
  logic [XW-1:0]          t95x;
  logic [XW-1:0]          t99x;
  logic [XW-1:0]          t999x;
  logic                   f95;
  logic                   f99;
  logic                   f999;
  logic [BIN_W-1:0]       b95;
  logic [BIN_W-1:0]       b99;
  logic [BIN_W-1:0]       b999;
  rsp_word_t              res;
  rsp_word_t              res_next;

  logic [31:0]            shifted;
  logic                   rec_ok;
  logic [SW-1:0]          cum_next;
  logic [XW-1:0]          c100_next;
  logic [XW-1:0]          c1000_next;
  logic [56:0]            wsum_add;
  logic                   scan_issue;
  logic                   pass1;
  logic                   pass2;
  logic                   pipe_empty;
  logic                   out_free;
  logic [63:0]            sum_w;
  logic [31:0]            maxb_w;
  logic [31:0]            b95_w;
  logic [31:0]            b99_w;
  logic [31:0]            b999_w;

  assign cmd_stall  = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign scan_issue = (state == S_P1) || (state == S_P2);
  assign pass1      = (state == S_P1) || (state == S_P1E);
  assign pass2      = (state == S_P2) || (state == S_P2E);
  assign pipe_empty = !rv && !pv;
  assign out_free   = !rsp_valid || !rsp_stall;

  // bin of a record sample and its range check
  assign shifted = cmd.latency >> bucket_shift;
  assign rec_ok  = (shifted < 32'(BINS));

  // running sums of the percentile scan
  assign cum_next   = cum + SW'(pcnt);
  assign c100_next  = c100 + pm100;
  assign c1000_next = c1000 + pm1000;
  assign wsum_add   = {1'b0, wsum} + 57'(pprod);

  // memory: one write port and one read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // read address select
  always_comb begin
    mem_raddr = scan_idx;
    if (state == S_IDLE) begin
      if (cmd.func == FUNC_READ) begin
        mem_raddr = BIN_W'(cmd.bin_index);
      end else begin
        mem_raddr = BIN_W'(shifted);
      end
    end
  end

  // write port: clearing pass or record write back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = rdata + COUNT_WIDTH'(1);
    if (state == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = '0;
    end else if (state == S_REC) begin
      mem_we = (rdata != COUNT_MAX);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR: begin
        if (clr_idx == LAST_BIN) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.func)
            FUNC_RECORD: if (rec_ok) state_next = S_REC;
            FUNC_REPORT: state_next = S_P1;
            FUNC_READ:   state_next = S_RD;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_REC: state_next = S_IDLE;
      S_RD:  state_next = S_OUT;
      S_P1: begin
        if (scan_idx == LAST_BIN) state_next = S_P1E;
      end
      S_P1E: begin
        if (pipe_empty) state_next = (sum == '0) ? S_OUT : S_TH;
      end
      S_TH: state_next = S_P2;
      S_P2: begin
        if (scan_idx == LAST_BIN) state_next = S_P2E;
      end
      S_P2E: begin
        if (pipe_empty) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_idx       <= '0;
      bucket_shift  <= '0;
      total_samples <= '0;
      rv            <= 1'b0;
      pv            <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR) clr_idx <= clr_idx + BIN_W'(1);
      if (cfg_valid) bucket_shift <= cfg_data;
      // count a sample that moved its bin
      if (state == S_REC && rdata != COUNT_MAX && total_samples != TOTAL_MAX) begin
        total_samples <= total_samples + 44'd1;
      end
      rv <= scan_issue;
      pv <= rv;
      // hand the result to the output register, drop it once taken
      if (state == S_OUT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // scan pipeline: read, then products, then accumulate
  always_ff @(posedge clk) begin
    ridx   <= scan_idx;
    pidx   <= ridx;
    pcnt   <= rdata;
    pprod  <= SW'(ridx) * SW'(rdata);
    pm100  <= XW'(rdata) * XW'(100);
    pm1000 <= XW'(rdata) * XW'(1000);
  end

  // build the pending result
  always_comb begin
    res_next = res;
    if (state == S_RD) begin
      res_next             = '0;
      res_next.bin_count   = cur_ok ? 32'(rdata) : 32'd0;
      res_next.above_floor = cur_ok && (44'(rdata) > (total_samples >> 10));
    end
    if (state == S_P1E && pipe_empty && sum == '0) begin
      res_next           = '0;
      res_next.empty_res = 1'b1;
    end
    if (state == S_P2E && pipe_empty) begin
      res_next              = '0;
      res_next.total_count  = (sum_w > 64'(TOTAL_MAX)) ? TOTAL_MAX : sum_w[43:0];
      res_next.weighted_sum = wsum;
      res_next.max_bin      = maxb_w[11:0];
      res_next.p95_bin      = b95_w[11:0];
      res_next.p99_bin      = b99_w[11:0];
      res_next.p999_bin     = b999_w[11:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      cur_addr <= mem_raddr;
      cur_ok   <= (32'(cmd.bin_index) < 32'(BINS));
      scan_idx <= '0;
      sum      <= '0;
      wsum     <= '0;
      maxb     <= '0;
    end
    if (scan_issue) scan_idx <= scan_idx + BIN_W'(1);

    // first pass: total, weighted sum, highest bin
    if (pv && pass1) begin
      sum  <= sum + SW'(pcnt);
      wsum <= wsum_add[56] ? WSUM_MAX : wsum_add[55:0];
      if (pcnt != '0) maxb <= pidx;
    end

    // thresholds scaled so that no division is needed
    if (state == S_TH) begin
      t95x     <= XW'(sum) * XW'(95);
      t99x     <= XW'(sum) * XW'(99);
      t999x    <= XW'(sum) * XW'(999);
      cum      <= '0;
      c100     <= XW'(100);
      c1000    <= XW'(1000);
      f95      <= 1'b0;
      f99      <= 1'b0;
      f999     <= 1'b0;
      scan_idx <= '0;
    end

    // second pass: cum >= floor(95S/100) holds when 100*(cum+1) > 95S
    if (pv && pass2) begin
      cum   <= cum_next;
      c100  <= c100_next;
      c1000 <= c1000_next;
      if (!f95 && cum_next != '0 && c100_next > t95x) begin
        f95 <= 1'b1;
        b95 <= pidx;
      end
      if (!f99 && cum_next != '0 && c100_next > t99x) begin
        f99 <= 1'b1;
        b99 <= pidx;
      end
      if (!f999 && cum_next != '0 && c1000_next > t999x) begin
        f999 <= 1'b1;
        b999 <= pidx;
      end
    end

    res <= res_next;

    if (state == S_OUT && out_free) rsp <= res;
  end

  // widen before masking bin numbers and saturating the total
  assign sum_w  = 64'(sum);
  assign maxb_w = 32'(maxb);
  assign b95_w  = 32'(b95);
  assign b99_w  = 32'(b99);
  assign b999_w = 32'(b999);

  `LHP_CHECK_NOW(a_full_bin_holds, (state == S_REC && rdata == COUNT_MAX), !mem_we,
                 "write to a bin at its count limit")
  `LHP_CHECK_NEXT(a_total_monotone, 1'b1, total_samples >= $past(total_samples),
                  "sample total went down")
  `LHP_CHECK_NOW(a_rsp_from_out, $rose(rsp_valid), $past(state == S_OUT),
                 "result word raised outside the delivery step")
  `LHP_CHECK_NOW(a_pct_order, (state == S_OUT && f999), (b95 <= b99 && b99 <= b999),
                 "percentile bins out of order")

endmodule

`default_nettype wire
